// File: rtl/hlt_pkg.sv
// Package for the handle lifecycle table: codes, slot record and control/status structs.
package hlt_pkg;

  localparam logic [2:0] OP_ADD     = 3'd0;
  localparam logic [2:0] OP_DRAIN   = 3'd1;
  localparam logic [2:0] OP_DETACH  = 3'd2;
  localparam logic [2:0] OP_RELEASE = 3'd3;
  localparam logic [2:0] OP_RETAIN  = 3'd4;
  localparam logic [2:0] OP_REL_ALL = 3'd5;
  localparam logic [2:0] OP_CLEAR   = 3'd6;

  localparam logic [2:0] ST_ACTIVE   = 3'd0;
  localparam logic [2:0] ST_DRAINING = 3'd1;
  localparam logic [2:0] ST_DETACHED = 3'd2;
  localparam logic [2:0] ST_RELEASED = 3'd3;
  localparam logic [2:0] ST_RETAINED = 3'd4;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 112;

  typedef struct packed {
    logic [31:0] handle;
    logic [2:0]  state;
    logic        hook;
    logic [31:0] gen;
  } slot_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_RD,
    S_CHK,
    S_EMIT,
    S_POP_RD,
    S_POP_EMIT
  } ctl_state_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic step;
    logic hit;
    logic pop_init;
    logic emit;
    logic pop;
  } hlt_cmd_t;

  typedef struct packed {
    logic search;
    logic rel_all;
    logic count_zero;
    logic match;
    logic idx_last;
    logic idx_zero;
    logic out_free;
  } hlt_sts_t;

endpackage

// File: rtl/hlt_ctrl.sv
// Sequencer for lookups, single-entry updates and release-all pops.
module hlt_ctrl
  import hlt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  hlt_sts_t sts,
  output hlt_cmd_t cmd
);

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.search && !sts.count_zero) begin
          state_nxt = S_RD;
        end else if (sts.rel_all && !sts.count_zero) begin
          cmd.pop_init = 1'b1;
          state_nxt    = S_POP_RD;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (sts.match) begin
          cmd.hit   = 1'b1;
          state_nxt = S_EMIT;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = sts.idx_last ? S_EMIT : S_RD;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_POP_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_POP_EMIT;
      end
      S_POP_EMIT: begin
        if (sts.out_free) begin
          cmd.pop   = 1'b1;
          state_nxt = sts.idx_zero ? S_IDLE : S_POP_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/hlt_dp.sv
// Datapath: slot memory, count and generation registers, result register.
module hlt_dp
  import hlt_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  hlt_cmd_t              cmd,
  output hlt_sts_t              sts,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [2:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast
);

  localparam int CW = $clog2(SLOTS + 1);
  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  slot_t mem [SLOTS];

  logic [2:0]    op_r;
  logic [31:0]   h_r;
  logic [2:0]    ist_r;
  logic          hk_r;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          found_r, found_nxt;
  slot_t         rd_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [31:0]   tgen_r, tgen_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                  out_last_r, out_last_nxt;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  slot_t         wr_data;

  logic        r_ok, r_hook, r_last, add_ok, lc_ok, live;
  logic [31:0] r_handle, r_gen;
  logic [2:0]  r_state, ns;
  logic        h_zero;

  assign h_zero = (h_r == 32'd0);

  always_comb begin
    sts            = '0;
    sts.search     = ((op_r == OP_ADD) && !h_zero) || (op_r == OP_DRAIN) ||
                     (op_r == OP_DETACH) || (op_r == OP_RELEASE) || (op_r == OP_RETAIN);
    sts.rel_all    = (op_r == OP_REL_ALL);
    sts.count_zero = (count_r == '0);
    sts.match      = (rd_r.handle == h_r);
    sts.idx_last   = ((idx_r + CW'(1)) == count_r);
    sts.idx_zero   = (idx_r == '0);
    sts.out_free   = !out_valid_r || out_tready;
  end

  always_comb begin
    idx_nxt   = idx_r;
    found_nxt = found_r;
    count_nxt = count_r;
    tgen_nxt  = tgen_r;
    wr_en     = 1'b0;
    wr_addr   = idx_r[AW-1:0];
    wr_data   = rd_r;
    r_ok      = 1'b0;
    r_handle  = h_r;
    r_hook    = 1'b0;
    r_state   = 3'd0;
    r_gen     = 32'd0;
    r_last    = 1'b1;
    add_ok    = 1'b0;
    lc_ok     = 1'b0;
    ns        = rd_r.state;
    live      = (rd_r.state == ST_ACTIVE) || (rd_r.state == ST_DRAINING);

    if (cmd.load) begin
      idx_nxt   = '0;
      found_nxt = 1'b0;
    end
    if (cmd.step) begin
      idx_nxt = idx_r + CW'(1);
    end
    if (cmd.hit) begin
      found_nxt = 1'b1;
    end
    if (cmd.pop_init) begin
      idx_nxt = count_r - CW'(1);
    end

    if (cmd.emit) begin
      case (op_r)
        OP_ADD: begin
          add_ok = !h_zero && (ist_r <= ST_RETAINED) && (count_r < CW'(SLOTS)) && !found_r;
          r_ok   = add_ok;
          if (found_r) begin
            r_state = rd_r.state;
            r_gen   = rd_r.gen;
          end else if (add_ok) begin
            wr_en          = 1'b1;
            wr_addr        = count_r[AW-1:0];
            wr_data.handle = h_r;
            wr_data.state  = ist_r;
            wr_data.hook   = hk_r;
            wr_data.gen    = tgen_r;
            count_nxt      = count_r + CW'(1);
            r_state        = ist_r;
            r_gen          = tgen_r;
          end
        end
        OP_DRAIN, OP_DETACH, OP_RELEASE, OP_RETAIN: begin
          if (found_r) begin
            case (op_r)
              OP_DRAIN: begin
                lc_ok = (rd_r.state == ST_ACTIVE);
                ns    = ST_DRAINING;
              end
              OP_DETACH: begin
                lc_ok = (rd_r.state != ST_RELEASED);
                ns    = ST_DETACHED;
              end
              OP_RELEASE: begin
                lc_ok = live;
                ns    = ST_RELEASED;
              end
              default: begin
                lc_ok = (rd_r.state != ST_RELEASED);
                ns    = ST_RETAINED;
              end
            endcase
            r_ok    = lc_ok;
            r_hook  = lc_ok && (op_r == OP_RELEASE) && rd_r.hook;
            r_state = lc_ok ? ns : rd_r.state;
            r_gen   = lc_ok ? (rd_r.gen + 32'd1) : rd_r.gen;
            if (lc_ok) begin
              wr_en         = 1'b1;
              wr_data.state = ns;
              wr_data.gen   = rd_r.gen + 32'd1;
            end
          end
        end
        OP_REL_ALL: begin
          r_ok     = 1'b1;
          r_handle = 32'd0;
        end
        OP_CLEAR: begin
          r_ok      = 1'b1;
          count_nxt = '0;
          tgen_nxt  = 32'd1;
        end
        default: begin
          r_ok = 1'b0;
        end
      endcase
    end

    if (cmd.pop) begin
      r_ok      = 1'b1;
      r_handle  = rd_r.handle;
      r_hook    = live && rd_r.hook;
      r_state   = live ? ST_RELEASED : rd_r.state;
      r_gen     = rd_r.gen;
      r_last    = (count_r == CW'(1));
      count_nxt = count_r - CW'(1);
      tgen_nxt  = tgen_r + 32'd1;
      idx_nxt   = idx_r - CW'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    if (cmd.emit || cmd.pop) begin
      out_valid_nxt = 1'b1;
      out_last_nxt  = r_last;
      out_data_nxt  = {6'd0, 5'(count_nxt), tgen_nxt, r_gen, r_state, r_hook, r_handle, r_ok};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd) begin
      rd_r <= mem[idx_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_tuser;
      h_r   <= in_tdata[31:0];
      ist_r <= in_tdata[34:32];
      hk_r  <= in_tdata[35];
    end
    idx_r      <= idx_nxt;
    found_r    <= found_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      tgen_r      <= 32'd1;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      tgen_r      <= tgen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

// File: rtl/handle_lifecycle_table.sv
// Handle lifecycle table: top level joining the sequencer and the datapath.
//
// Input channel in_*: one command item per handshake; op travels in in_tuser,
// handle, init_state and has_hook in in_tdata. Result channel out_*: one
// result item per handshake, out_tlast on the final result of a command.
// A command is taken only while the sequencer is idle, but a finished result
// may still wait in the output register while the next command is taken.
// A lookup reads the slot memory one entry at a time (a read state, then a
// compare state) for drain, detach, release, retain and add, scanning up to
// the number of held entries (at most SLOTS) and stopping at a match. Clear,
// unknown ops and release-all on an empty table go straight to the result.
// Release-all gives one result per held entry, popping from the top down.
// Reset empties the table and sets the table generation to one; the slot
// memory is not cleared, held entries are always written before being read.
// When out_tready is low the result holds and the block waits before
// producing the next one; nothing is dropped.
module handle_lifecycle_table
  import hlt_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [31:0] handle, [34:32] init_state, [35] has_hook
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [2:0] op
  input  logic [2:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [0] ok, [32:1] out_handle, [33] hook_fired, [36:34] entry_state,
  // [68:37] entry_generation, [100:69] table_generation, [105:101] entry_count
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast
);

  hlt_cmd_t cmd;
  hlt_sts_t sts;

  hlt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  hlt_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

`ifndef SYNTHESIS
  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a command is in progress");

  a_emit_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_tvalid && out_tlast)
    else $error("single result not marked last");

  a_pop_last_at_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |=> out_tvalid && (out_tlast == sts.count_zero))
    else $error("release-all last flag disagrees with entry count");
`endif

endmodule
